// File: sv/srwl_pkg.sv
package srwl_pkg;

  localparam int NUM_HANDLES = 16;
  localparam int MAX_NESTING = 255;

  // Handle field is 4 bits wide, so at most 16 slots are ever addressed
  localparam int HANDLE_SLOTS = 16;
  localparam logic [4:0] HANDLE_LIMIT = 5'((NUM_HANDLES > 16) ? 16 : NUM_HANDLES);
  localparam logic [7:0] NEST_LIMIT = 8'((MAX_NESTING > 255) ? 255 : MAX_NESTING);

  localparam logic [2:0] REQ_UNLOCK  = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_WRITE   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic [1:0] MODE_UNLOCKED = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_WRITE    = 2'd2;

  typedef struct packed {
    logic       auto_downgrade;
    logic       convert_to_read;
    logic [3:0] handle_id;
    logic [2:0] req_type;
  } req_t;

  typedef struct packed {
    logic       any_holder;
    logic [7:0] own_nesting;
    logic [1:0] mode_after;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] mode;
    logic       set_holder;
    logic       inc;
  } take_t;

  // Lock request against the current mode for one handle
  function automatic take_t take_lock(input logic [1:0] mode, input logic holder,
                                      input logic [7:0] nest, input logic op_read,
                                      input logic conv);
    take_t r;
    logic  join_lock;
    r.status     = ST_BUSY;
    r.mode       = mode;
    r.set_holder = 1'b0;
    r.inc        = 1'b0;
    join_lock    = 1'b0;
    if (mode == MODE_UNLOCKED) begin
      join_lock = 1'b1;
    end else if (holder) begin
      if (mode == MODE_READ && op_read) begin
        if (nest >= NEST_LIMIT) begin
          r.status = ST_INVALID;
        end else begin
          r.inc    = 1'b1;
          r.status = ST_OK;
        end
      end else if (conv) begin
        if (mode == MODE_WRITE && op_read) begin
          r.mode   = MODE_READ;
          r.status = ST_OK;
        end else begin
          r.status = ST_INVALID;
        end
      end
    end else begin
      if (conv) begin
        r.status = ST_INVALID;
      end else if (op_read && mode == MODE_READ) begin
        join_lock = 1'b1;
      end
    end
    if (join_lock) begin
      if (nest >= NEST_LIMIT) begin
        r.status = ST_INVALID;
      end else begin
        r.set_holder = 1'b1;
        r.mode       = op_read ? MODE_READ : MODE_WRITE;
        r.inc        = 1'b1;
        r.status     = ST_OK;
      end
    end
    return r;
  endfunction

endpackage

// File: sv/shared_reader_writer_lock_unit.sv
// Reader-writer lock shared by up to 16 handles, one request per word.
// Slave channel s_axis carries requests (req_type, handle_id, conversion
// and auto-downgrade flags); master channel m_axis returns one result word
// per request (status, mode after the request, the requester's nesting
// count and whether any handle still holds the lock).
// A request word is captured in an input register; when the output register
// is free or draining, the lock state is read, updated and the result loaded
// into the output register. One request is taken every cycle while the
// receiver keeps m_axis_tready high: the state update is a single bitmap
// test, an 8-bit count step and a mode change, so the next request sees it at
// once. A request that would block answers busy straight away; retry is up
// to the requester.
// Reset (rst, synchronous) unlocks the lock, clears all holders and zeroes
// every nesting count; both registers are emptied.
// If the receiver holds m_axis_tready low, the result word is held, the
// input register fills and then s_axis_tready drops; nothing is lost.
module shared_reader_writer_lock_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[2:0], handle_id[6:3], convert_to_read[7], auto_downgrade[8], zero[15:9]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], mode_after[3:2], own_nesting[11:4], any_holder[12], zero[15:13]
  output logic [15:0] m_axis_tdata
);

  logic            in_valid;
  srwl_pkg::req_t  in_req;
  logic            out_valid;
  srwl_pkg::res_t  out_res;
  srwl_pkg::res_t  core_res;
  logic            advance;

  // Move the held request on when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= srwl_pkg::req_t'(s_axis_tdata[8:0]);
    end
  end

  srwl_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (in_req),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res};

endmodule

// File: sv/srwl_core.sv
module srwl_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  srwl_pkg::req_t     req,
  output srwl_pkg::res_t     res
);

  logic [1:0]  lock_mode;
  logic [15:0] holder_bits;
  logic [7:0]  nesting_count [srwl_pkg::HANDLE_SLOTS];

  logic [1:0]  lock_mode_next;
  logic [15:0] holder_bits_next;
  logic [7:0]  nest_next;
  logic        nest_we;
  logic [1:0]  status;

  logic [3:0]  h;
  logic        holder;
  logic [7:0]  nest;
  logic        valid_h;
  logic [15:0] hbit;
  logic [7:0]  dec;
  srwl_pkg::take_t tk;

  always_comb begin
    h       = req.handle_id;
    hbit    = 16'(1) << h;
    holder  = holder_bits[h];
    nest    = nesting_count[h];
    valid_h = {1'b0, h} < srwl_pkg::HANDLE_LIMIT;
    dec     = (nest != 8'd0) ? nest - 8'd1 : 8'd0;
    tk      = srwl_pkg::take_lock(lock_mode, holder, nest, req.req_type == srwl_pkg::REQ_READ,
                                  (req.req_type == srwl_pkg::REQ_READ) ?
                                  (req.convert_to_read | (req.auto_downgrade & holder)) :
                                  req.convert_to_read);

    lock_mode_next   = lock_mode;
    holder_bits_next = holder_bits;
    nest_next        = nest;
    nest_we          = 1'b0;
    status           = srwl_pkg::ST_INVALID;

    unique case (req.req_type)
      srwl_pkg::REQ_QUERY: begin
        status = (lock_mode == srwl_pkg::MODE_UNLOCKED) ? srwl_pkg::ST_OK : srwl_pkg::ST_BUSY;
      end
      srwl_pkg::REQ_UNLOCK: begin
        if (valid_h && lock_mode != srwl_pkg::MODE_UNLOCKED && holder) begin
          nest_next = dec;
          nest_we   = 1'b1;
          if (dec == 8'd0) begin
            holder_bits_next = holder_bits & ~hbit;
            if (holder_bits_next == 16'd0) begin
              lock_mode_next = srwl_pkg::MODE_UNLOCKED;
            end
          end
          status = srwl_pkg::ST_OK;
        end
      end
      srwl_pkg::REQ_READ, srwl_pkg::REQ_WRITE: begin
        if (valid_h) begin
          status         = tk.status;
          lock_mode_next = tk.mode;
          if (tk.set_holder) begin
            holder_bits_next = holder_bits | hbit;
          end
          if (tk.inc) begin
            nest_next = nest + 8'd1;
            nest_we   = 1'b1;
          end
        end
      end
      srwl_pkg::REQ_RELEASE: begin
        if (valid_h) begin
          if (holder) begin
            holder_bits_next = holder_bits & ~hbit;
            if (holder_bits_next == 16'd0) begin
              lock_mode_next = srwl_pkg::MODE_UNLOCKED;
            end
          end
          nest_next = 8'd0;
          nest_we   = 1'b1;
          status    = srwl_pkg::ST_OK;
        end
      end
      default: begin
        status = srwl_pkg::ST_INVALID;
      end
    endcase

    res.status      = status;
    res.mode_after  = lock_mode_next;
    res.own_nesting = valid_h ? nest_next : 8'd0;
    res.any_holder  = |holder_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_mode   <= srwl_pkg::MODE_UNLOCKED;
      holder_bits <= '0;
      for (int i = 0; i < srwl_pkg::HANDLE_SLOTS; i++) begin
        nesting_count[i] <= '0;
      end
    end else if (en) begin
      lock_mode   <= lock_mode_next;
      holder_bits <= holder_bits_next;
      if (nest_we) begin
        nesting_count[h] <= nest_next;
      end
    end
  end

`ifndef SYNTHESIS
  logic [15:0] zero_nest;

  always_comb begin
    for (int i = 0; i < srwl_pkg::HANDLE_SLOTS; i++) begin
      zero_nest[i] = (nesting_count[i] == 8'd0);
    end
  end

  a_mode_matches_holders: assert property (@(posedge clk) disable iff (rst)
    (lock_mode == srwl_pkg::MODE_UNLOCKED) == (holder_bits == 16'd0))
    else $error("lock mode disagrees with holder set");

  a_write_single_holder: assert property (@(posedge clk) disable iff (rst)
    (lock_mode == srwl_pkg::MODE_WRITE) |-> $onehot(holder_bits))
    else $error("write lock without exactly one holder");

  a_holder_nonzero_nest: assert property (@(posedge clk) disable iff (rst)
    (holder_bits & zero_nest) == 16'd0)
    else $error("holder with zero nesting");

  a_busy_no_change: assert property (@(posedge clk) disable iff (rst)
    (en && status == srwl_pkg::ST_BUSY) |=> ($stable(lock_mode) && $stable(holder_bits)))
    else $error("busy request changed lock state");
`endif

endmodule
